@@ hdl/rhcc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhcc_pkg: shared types, constants and microcode for the heating curve block
// Holds the control word layout, the program table, register indexes and the
// reciprocal constants that replace the divisions by 320 and 25600.
// ----------------------------------------------------------------------------
package rhcc_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_HEAT_ENABLE = 3'd0,
      CSR_SETPOINT    = 3'd1,
      CSR_CYCLE_LEN   = 3'd2,
      CSR_DUTY_M10    = 3'd3,
      CSR_DUTY_P10    = 3'd4,
      CSR_INT_GAIN    = 3'd5
   } csr_index_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   // operand pair routed to the shared multiplier
   typedef enum logic [2:0] {
      MUL_NONE      = 3'd0,
      MUL_CURVE     = 3'd1,
      MUL_INTEG     = 3'd2,
      MUL_RECIP5    = 3'd3,
      MUL_RECIP_CYC = 3'd4,
      MUL_DUTY_A    = 3'd5,
      MUL_DUTY_B    = 3'd6,
      MUL_RECIP25   = 3'd7
   } mul_sel_type;

   typedef enum logic {
      JMP_NONE,
      JMP_CLAMP
   } jump_type;

   typedef logic [3:0] pc_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        ld_acc;
      logic        ld_mag;
      logic        ld_iterm;
      logic        ld_curve;
      logic        ld_duty;
      logic        ld_split_a;
      logic        ld_split_b;
      logic        ld_clamp;
      logic        ld_hi;
      logic        ld_sum;
      jump_type    jmp;
      pc_type      jmp_target;
      logic        last;
   } ucode_type;

   localparam pc_type STEP_OUT = 4'd9;

   // reset values of the configuration registers
   localparam logic signed [12:0] SETPOINT_RST  = 13'sd320;
   localparam logic [31:0]        CYCLE_LEN_RST = 32'd60000;
   localparam logic signed [15:0] DUTY_M10_RST  = 16'sd25600;

   // curve argument is outdoor + setpoint - 20 C + 10 C, in 1/16 C
   localparam int CURVE_BIAS = 160;
   localparam int FULL_DUTY  = 25600;

   // floor(n/5) = (n * RECIP_5) >> 26 for n < 2^24
   localparam logic signed [32:0] RECIP_5      = 33'sd13421773;
   // floor(n/25) = (n * RECIP_25_CYC) >> 27 for n < 2^22
   localparam logic signed [32:0] RECIP_25_CYC = 33'sd5368710;
   // floor(n/25) = (n * RECIP_25) >> 25 for n < 2^20
   localparam logic signed [32:0] RECIP_25     = 33'sd1342178;

   // program table: one control word per step
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type uc;
      uc = '0;
      unique case (pc)
         4'd0: begin
            uc.ld_acc  = 1'b1;
            uc.mul_sel = MUL_CURVE;
         end
         4'd1: begin
            uc.ld_mag  = 1'b1;
            uc.mul_sel = MUL_INTEG;
         end
         4'd2: begin
            uc.ld_iterm = 1'b1;
            uc.mul_sel  = MUL_RECIP5;
         end
         4'd3: begin
            uc.ld_curve = 1'b1;
            uc.mul_sel  = MUL_RECIP_CYC;
         end
         4'd4: begin
            uc.ld_duty    = 1'b1;
            uc.ld_split_a = 1'b1;
         end
         4'd5: begin
            uc.ld_clamp   = 1'b1;
            uc.ld_split_b = 1'b1;
            uc.mul_sel    = MUL_DUTY_A;
            uc.jmp        = JMP_CLAMP;
            uc.jmp_target = STEP_OUT;
         end
         4'd6: begin
            uc.ld_hi   = 1'b1;
            uc.mul_sel = MUL_DUTY_B;
         end
         4'd7: begin
            uc.mul_sel = MUL_RECIP25;
         end
         4'd8: begin
            uc.ld_sum = 1'b1;
         end
         4'd9: begin
            uc.last = 1'b1;
         end
         default: begin
            uc.last = 1'b1;
         end
      endcase
      return uc;
   endfunction

endpackage

@@ hdl/radiator_heating_curve_controller.sv @@
// ----------------------------------------------------------------------------
// radiator_heating_curve_controller: weather compensated heating curve
// One heating channel: linear outdoor curve plus integral action on the room
// error, reporting duty, integral term and relay on-time per control cycle.
// ----------------------------------------------------------------------------
//
//   channel  ports   direction  beat
//   req_     in      in         tick: time_ms, outdoor_temp, room_temp
//   rsp_     out     out        duty_percent, integral_term, on_time_ms
//   csr_     cfg     in         register index and write data
//
// A tick that fires a control cycle runs a 10-step microprogram (7 steps when
// the duty clamps to 0 or full scale) on one shared 33x33 multiplier after its
// accepting cycle, and no further tick is taken until the program finishes;
// a tick that does not fire leaves the sequencer idle and yields no beat.
// Reset is synchronous and restores the register defaults and cleared state.
// req_ready drops while the program runs; a result waiting on rsp_ready holds
// only the final step, the next tick is accepted once the program finishes.

module radiator_heating_curve_controller
   import rhcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_time_ms,
   input  logic signed [12:0] req_outdoor_temp,
   input  logic signed [12:0] req_room_temp,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_duty_percent,
   output logic signed [31:0] rsp_integral_term,
   output logic [31:0]        rsp_on_time_ms,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   // configuration
   logic               heat_en_ff;
   logic signed [12:0] setpoint_ff;
   logic [31:0]        cycle_len_ff;
   logic signed [15:0] m10_ff;
   logic signed [15:0] p10_ff;
   logic signed [15:0] gain_ff;

   // control state
   logic [31:0]        cycle_start_ff;
   logic signed [31:0] acc_ff;
   logic signed [31:0] acc_in;
   seq_state_type      seq_state_ff;
   seq_state_type      seq_state_in;
   pc_type             pc_ff;
   pc_type             pc_in;
   logic               rsp_valid_ff;

   // datapath
   logic signed [14:0] t_ff;
   logic signed [13:0] err_ff;
   logic signed [16:0] d_ff;
   logic signed [65:0] prod_ff;
   logic signed [65:0] prod_in;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic               neg_ff;
   logic [23:0]        mag_ff;
   logic signed [31:0] iterm_ff;
   logic signed [31:0] iterm_in;
   logic signed [31:0] curve_ff;
   logic signed [31:0] curve_in;
   logic signed [31:0] duty_ff;
   logic signed [31:0] duty_in;
   logic [17:0]        a_ff;
   logic [14:0]        b_ff;
   logic [31:0]        hi_ff;
   logic [31:0]        on_time_ff;
   logic signed [31:0] rsp_duty_ff;
   logic signed [31:0] rsp_iterm_ff;
   logic [31:0]        rsp_on_time_ff;

   ucode_type          uc;
   logic               req_accept;
   logic               fire;
   logic [31:0]        elapsed;
   logic               step_en;
   logic               out_load;
   logic               clamp;
   logic               jump_taken;
   logic signed [32:0] acc_sum;
   logic signed [31:0] prod_lo;
   logic [31:0]        abs_prod;
   logic signed [39:0] iterm_shift;
   logic signed [31:0] q_curve;
   logic signed [32:0] duty_sum;
   logic [31:0]        b_full;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid & req_ready;
   assign elapsed    = req_time_ms - cycle_start_ff;
   assign fire       = heat_en_ff & (elapsed >= cycle_len_ff);
   assign uc         = ucode_rom(pc_ff);
   assign clamp      = (duty_ff <= 32'sd0) || (duty_ff >= FULL_DUTY);
   assign jump_taken = (uc.jmp == JMP_CLAMP) && clamp;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         heat_en_ff   <= 1'b0;
         setpoint_ff  <= SETPOINT_RST;
         cycle_len_ff <= CYCLE_LEN_RST;
         m10_ff       <= DUTY_M10_RST;
         p10_ff       <= '0;
         gain_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEAT_ENABLE: heat_en_ff   <= csr_wdata[0];
            CSR_SETPOINT:    setpoint_ff  <= csr_wdata[12:0];
            CSR_CYCLE_LEN:   cycle_len_ff <= csr_wdata;
            CSR_DUTY_M10:    m10_ff       <= csr_wdata[15:0];
            CSR_DUTY_P10:    p10_ff       <= csr_wdata[15:0];
            CSR_INT_GAIN:    gain_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      seq_state_in = seq_state_ff;
      pc_in        = pc_ff;
      unique case (seq_state_ff)
         SEQ_IDLE: begin
            if (req_accept && fire) begin
               seq_state_in = SEQ_RUN;
               pc_in        = '0;
            end
         end
         SEQ_RUN: begin
            if (uc.last) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  seq_state_in = SEQ_IDLE;
               end
            end else if (jump_taken) begin
               pc_in = uc.jmp_target;
            end else begin
               pc_in = pc_ff + 4'd1;
            end
         end
         default: seq_state_in = SEQ_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      step_en   = 1'b0;
      out_load  = 1'b0;
      unique case (seq_state_ff)
         SEQ_IDLE: req_ready = 1'b1;
         SEQ_RUN: begin
            step_en  = 1'b1;
            out_load = uc.last & (~rsp_valid_ff | rsp_ready);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff   <= SEQ_IDLE;
         pc_ff          <= '0;
         cycle_start_ff <= '0;
         acc_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         seq_state_ff <= seq_state_in;
         pc_ff        <= pc_in;
         if (req_accept && fire) begin
            cycle_start_ff <= req_time_ms;
         end
         if (step_en && uc.ld_acc) begin
            acc_ff <= acc_in;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (uc.mul_sel)
         MUL_CURVE: begin
            mul_a = 33'(t_ff);
            mul_b = 33'(d_ff);
         end
         MUL_INTEG: begin
            mul_a = 33'(acc_ff);
            mul_b = 33'(gain_ff);
         end
         MUL_RECIP5: begin
            mul_a = {9'd0, mag_ff};
            mul_b = RECIP_5;
         end
         MUL_RECIP_CYC: begin
            mul_a = {11'd0, cycle_len_ff[31:10]};
            mul_b = RECIP_25_CYC;
         end
         MUL_DUTY_A: begin
            mul_a = {18'd0, duty_ff[14:0]};
            mul_b = {15'd0, a_ff};
         end
         MUL_DUTY_B: begin
            mul_a = {18'd0, duty_ff[14:0]};
            mul_b = {18'd0, b_ff};
         end
         MUL_RECIP25: begin
            mul_a = {13'd0, prod_ff[29:10]};
            mul_b = RECIP_25;
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // datapath arithmetic
   always_comb begin
      acc_sum = 33'(acc_ff) + 33'(err_ff);
      if (gain_ff == 16'sd0) begin
         acc_in = '0;
      end else if (acc_sum[32] != acc_sum[31]) begin
         acc_in = acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         acc_in = acc_sum[31:0];
      end

      prod_lo  = prod_ff[31:0];
      abs_prod = prod_ff[65] ? 32'(-prod_lo) : 32'(prod_lo);

      // arithmetic shift of the product floors toward minus infinity
      iterm_shift = prod_ff[47:8];
      if (iterm_shift > 40'sh00_7FFF_FFFF) begin
         iterm_in = 32'sh7FFF_FFFF;
      end else if (iterm_shift < -40'sh00_8000_0000) begin
         iterm_in = 32'sh8000_0000;
      end else begin
         iterm_in = iterm_shift[31:0];
      end

      // quotient magnitude, then restore the sign: truncation toward zero
      q_curve  = 32'({10'd0, prod_ff[47:26]});
      curve_in = 32'(m10_ff) + (neg_ff ? -q_curve : q_curve);

      duty_sum = 33'(curve_ff) + 33'(iterm_ff);
      if (duty_sum[32] != duty_sum[31]) begin
         duty_in = duty_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         duty_in = duty_sum[31:0];
      end

      // remainder of cycle over 25600, 25600 = 2^14 + 2^13 + 2^10
      b_full = cycle_len_ff - {a_ff, 14'd0} - {1'b0, a_ff, 13'd0}
             - {4'd0, a_ff, 10'd0};
   end

   always_ff @(posedge clock) begin
      if (req_accept && fire) begin
         t_ff   <= 15'(req_outdoor_temp) + 15'(setpoint_ff) - 15'(CURVE_BIAS);
         err_ff <= 14'(setpoint_ff) - 14'(req_room_temp);
         d_ff   <= 17'(p10_ff) - 17'(m10_ff);
      end
      if (step_en) begin
         prod_ff <= prod_in;
         if (uc.ld_mag) begin
            neg_ff <= prod_ff[65];
            mag_ff <= abs_prod[29:6];
         end
         if (uc.ld_iterm) begin
            iterm_ff <= iterm_in;
         end
         if (uc.ld_curve) begin
            curve_ff <= curve_in;
         end
         if (uc.ld_duty) begin
            duty_ff <= duty_in;
         end
         if (uc.ld_split_a) begin
            a_ff <= prod_ff[44:27];
         end
         if (uc.ld_split_b) begin
            b_ff <= b_full[14:0];
         end
         if (uc.ld_clamp) begin
            on_time_ff <= (duty_ff <= 32'sd0) ? 32'd0 : cycle_len_ff;
         end
         if (uc.ld_hi) begin
            hi_ff <= prod_ff[31:0];
         end
         if (uc.ld_sum) begin
            on_time_ff <= hi_ff + {16'd0, prod_ff[40:25]};
         end
      end
      if (out_load) begin
         rsp_duty_ff    <= duty_ff;
         rsp_iterm_ff   <= iterm_ff;
         rsp_on_time_ff <= on_time_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_duty_percent  = rsp_duty_ff;
   assign rsp_integral_term = rsp_iterm_ff;
   assign rsp_on_time_ms    = rsp_on_time_ff;

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the radiator heating curve controller
// Drives time ticks and register writes through their valid/ready channels with
// random gaps on both sides. A behavioral copy of the curve, integral and
// on-time arithmetic predicts every control-cycle beat, and each beat is
// compared field by field in order. A directed table comes first, then random
// phases over several register settings, then runs with large room errors
// that pin the duty at both ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
   import rhcc_pkg::*;
();

   localparam int          SETTLE_CYCLES  = 24;
   localparam int          TAIL_CYCLES    = 40;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          MAX_REPORTS    = 100;
   localparam int          PHASE_COUNT    = 12;
   localparam int          PHASE_TICKS    = 100;
   localparam int          SAT_RUN_TICKS  = 40;
   localparam longint      SHIFT_20C      = 320;
   localparam longint      CURVE_LOW      = -160;
   localparam longint      CURVE_SPAN     = 320;
   localparam longint      FULL_SCALE     = 25600;
   // indexes with no register behind them
   localparam logic [2:0]  CSR_UNUSED_LO  = 3'd6;
   localparam logic [2:0]  CSR_UNUSED_HI  = 3'd7;

   typedef struct packed {
      logic signed [31:0] duty;
      logic signed [31:0] iterm;
      logic [31:0]        on_time;
   } heat_result_type;

   typedef enum logic {
      ROW_CSR,
      ROW_TICK
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [2:0]         idx;
      logic [31:0]        data;
      logic [31:0]        t;
      logic signed [12:0] outdoor;
      logic signed [12:0] room;
      logic               typed;
      heat_result_type    want;
   } step_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [31:0]        req_time_ms;
   logic signed [12:0] req_outdoor_temp;
   logic signed [12:0] req_room_temp;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_duty_percent;
   logic signed [31:0] rsp_integral_term;
   logic [31:0]        rsp_on_time_ms;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   // predictor copy of registers and state
   logic               heat_on;
   logic signed [12:0] target_temp;
   logic [31:0]        period_ms;
   logic signed [15:0] duty_cold;
   logic signed [15:0] duty_warm;
   logic signed [15:0] gain_i;
   logic [31:0]        cycle_mark;
   logic signed [31:0] err_sum;

   heat_result_type    heat_cycles_due[$];
   step_row_type       dir_rows[$];
   int                 fail_count;
   int                 idle_cycles;
   bit                 calm;
   int unsigned        rsp_hold;

   radiator_heating_curve_controller i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_time_ms      (req_time_ms),
      .req_outdoor_temp (req_outdoor_temp),
      .req_room_temp    (req_room_temp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_duty_percent (rsp_duty_percent),
      .rsp_integral_term(rsp_integral_term),
      .rsp_on_time_ms   (rsp_on_time_ms),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // most gaps short, a few long, none while calm
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [12:0] rand_temp();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 3) return -13'sd4096;
      if (r < 6) return 13'sd4095;
      if (r < 9) return 13'sd0;
      if (r < 12) return -13'sd1;
      return 13'($urandom);
   endfunction

   function automatic void apply_csr(input logic [2:0] idx, input logic [31:0] data);
      case (idx)
         CSR_HEAT_ENABLE: heat_on     = data[0];
         CSR_SETPOINT:    target_temp = data[12:0];
         CSR_CYCLE_LEN:   period_ms   = data;
         CSR_DUTY_M10:    duty_cold   = data[15:0];
         CSR_DUTY_P10:    duty_warm   = data[15:0];
         CSR_INT_GAIN:    gain_i      = data[15:0];
         default: ;
      endcase
   endfunction

   // advance the predictor by one tick; return 1 when a control cycle fires
   function automatic bit predict_heat_cycle(input logic [31:0] now,
                                             input logic signed [12:0] outdoor,
                                             input logic signed [12:0] room,
                                             output heat_result_type res);
      logic [31:0] elapsed;
      longint      x;
      longint      curve;
      longint      iterm;
      longint      duty;
      longint      prod;
      elapsed = now - cycle_mark;
      res     = '0;
      if (!heat_on || elapsed < period_ms) return 1'b0;
      cycle_mark = now;
      x     = longint'(outdoor) + longint'(target_temp) - SHIFT_20C;
      curve = longint'(duty_cold) +
              ((x - CURVE_LOW) * (longint'(duty_warm) - longint'(duty_cold))) / CURVE_SPAN;
      if (gain_i != 0) begin
         err_sum = clip32(longint'(err_sum) + longint'(target_temp) - longint'(room));
         prod    = longint'(err_sum) * longint'(gain_i);
         iterm   = clip32(prod >>> 8);
      end else begin
         err_sum = '0;
         iterm   = 0;
      end
      duty = clip32(curve + iterm);
      res.duty  = duty[31:0];
      res.iterm = iterm[31:0];
      if (duty <= 0) res.on_time = '0;
      else if (duty >= FULL_SCALE) res.on_time = period_ms;
      else res.on_time = (duty * longint'({32'b0, period_ms})) / FULL_SCALE;
      return 1'b1;
   endfunction

   function automatic step_row_type csr_row(input logic [2:0] idx, input logic [31:0] data);
      step_row_type r;
      r      = '0;
      r.kind = ROW_CSR;
      r.idx  = idx;
      r.data = data;
      return r;
   endfunction

   function automatic step_row_type tick_row(input logic [31:0] t, input int outdoor,
                                             input int room);
      step_row_type r;
      r         = '0;
      r.kind    = ROW_TICK;
      r.t       = t;
      r.outdoor = outdoor[12:0];
      r.room    = room[12:0];
      return r;
   endfunction

   function automatic step_row_type typed_row(input logic [31:0] t, input int outdoor,
                                              input int room, input int duty,
                                              input int iterm, input logic [31:0] on_time);
      step_row_type r;
      r              = tick_row(t, outdoor, room);
      r.typed        = 1'b1;
      r.want.duty    = duty;
      r.want.iterm   = iterm;
      r.want.on_time = on_time;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      else if (fail_count == MAX_REPORTS + 1)
         $display("%0t: further mismatches not shown", $time);
   endtask

   task automatic send_tick(input logic [31:0] t, input logic signed [12:0] outdoor,
                            input logic signed [12:0] room, input bit typed,
                            input heat_result_type want);
      int unsigned     gap;
      heat_result_type got;
      bit              fired;
      gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_time_ms      = t;
      req_outdoor_temp = outdoor;
      req_room_temp    = room;
      do @(posedge clock); while (!req_ready);
      fired = predict_heat_cycle(t, outdoor, room, got);
      if (typed) heat_cycles_due.push_back(want);
      else if (fired) heat_cycles_due.push_back(got);
   endtask

   // drop the tick channel and wait until the block has gone quiet
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (heat_cycles_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // write every register, with noise in the unused upper bits
   task automatic program_channel(input logic en, input logic signed [12:0] sp,
                                  input logic [31:0] cyc, input logic signed [15:0] m10,
                                  input logic signed [15:0] p10,
                                  input logic signed [15:0] gain);
      logic [31:0] noise;
      noise = $urandom;
      write_csr(CSR_HEAT_ENABLE, {noise[31:1], en});
      write_csr(CSR_SETPOINT, {noise[31:13], sp});
      write_csr(CSR_CYCLE_LEN, cyc);
      write_csr(CSR_DUTY_M10, {noise[15:0], m10});
      write_csr(CSR_DUTY_P10, {noise[31:16], p10});
      write_csr(CSR_INT_GAIN, {noise[23:8], gain});
   endtask

   task automatic random_ticks(input int count, input int pause_at);
      logic [31:0] t;
      int unsigned pick;
      for (int k = 0; k < count; k++) begin
         if (k == pause_at) settle();
         pick = $urandom_range(0, 99);
         // mostly land on or just past the cycle boundary so cycles fire
         if (pick < 55) t = cycle_mark + period_ms + $urandom_range(0, 3);
         else if (pick < 80 && period_ms != 0) t = cycle_mark + ($urandom % period_ms);
         else t = $urandom;
         send_tick(t, rand_temp(), rand_temp(), 1'b0, '0);
      end
   endtask

   // ready side: random stalls on the result channel
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_ready = 1'b1;
         rsp_hold  = 0;
      end else if (rsp_hold > 0) begin
         rsp_ready = 1'b0;
         rsp_hold  = rsp_hold - 1;
      end else begin
         rsp_ready = 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_hold = gap_len();
      end
   end

   always @(posedge clock) begin
      heat_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (heat_cycles_due.size() == 0) begin
            report_mismatch("unexpected beat, duty", 0, rsp_duty_percent);
         end else begin
            want = heat_cycles_due.pop_front();
            if (rsp_duty_percent !== want.duty)
               report_mismatch("duty_percent", want.duty, rsp_duty_percent);
            if (rsp_integral_term !== want.iterm)
               report_mismatch("integral_term", want.iterm, rsp_integral_term);
            if (rsp_on_time_ms !== want.on_time)
               report_mismatch("on_time_ms", {32'b0, want.on_time}, {32'b0, rsp_on_time_ms});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      step_row_type row;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_time_ms      = '0;
      req_outdoor_temp = '0;
      req_room_temp    = '0;
      rsp_ready        = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      fail_count       = 0;
      idle_cycles      = 0;
      calm             = 1'b0;
      rsp_hold         = 0;
      heat_on          = 1'b0;
      target_temp      = SETPOINT_RST;
      period_ms        = CYCLE_LEN_RST;
      duty_cold        = DUTY_M10_RST;
      duty_warm        = '0;
      gain_i           = '0;
      cycle_mark       = '0;
      err_sum          = '0;

      // directed table
      dir_rows.push_back(tick_row(32'd100000, 0, 0));               // heating off
      dir_rows.push_back(csr_row(CSR_HEAT_ENABLE, 32'd1));
      dir_rows.push_back(tick_row(32'd59999, 0, 0));                // one short of a cycle
      dir_rows.push_back(typed_row(32'd60000, 0, 0, 12800, 0, 32'd30000));
      dir_rows.push_back(tick_row(32'd119999, 0, 0));
      dir_rows.push_back(typed_row(32'd120000, -160, 0, 25600, 0, 32'd60000));
      dir_rows.push_back(typed_row(32'd180000, 160, 0, 0, 0, 32'd0));
      dir_rows.push_back(typed_row(32'd240000, -4096, 0, 340480, 0, 32'd60000));
      dir_rows.push_back(typed_row(32'd300000, 4095, 4095, -314800, 0, 32'd0));
      dir_rows.push_back(csr_row(CSR_CYCLE_LEN, 32'd0));             // zero cycle length
      dir_rows.push_back(typed_row(32'd300000, 0, 0, 12800, 0, 32'd0));
      dir_rows.push_back(csr_row(CSR_CYCLE_LEN, 32'hFFFF_FFFF));
      dir_rows.push_back(tick_row(32'd299998, 0, 0));
      dir_rows.push_back(typed_row(32'd299999, 0, 0, 12800, 0, 32'd2147483647));
      dir_rows.push_back(csr_row(CSR_CYCLE_LEN, 32'd1));
      dir_rows.push_back(csr_row(CSR_INT_GAIN, 32'd1));
      dir_rows.push_back(tick_row(32'hFFFF_FFFF, 0, 0));
      dir_rows.push_back(tick_row(32'd0, 0, 4095));                  // time wraps
      dir_rows.push_back(csr_row(CSR_SETPOINT, 32'hFFFF_F000));
      dir_rows.push_back(csr_row(CSR_INT_GAIN, 32'h0000_8000));
      dir_rows.push_back(csr_row(CSR_DUTY_M10, 32'h0000_8000));
      dir_rows.push_back(csr_row(CSR_DUTY_P10, 32'hFFFF_7FFF));
      dir_rows.push_back(tick_row(32'd5, -4096, 4095));
      dir_rows.push_back(tick_row(32'd6, 4095, -4096));
      dir_rows.push_back(csr_row(CSR_INT_GAIN, 32'h0000_0000));      // clears accumulator
      dir_rows.push_back(tick_row(32'd7, 1234, -77));
      dir_rows.push_back(csr_row(CSR_UNUSED_LO, 32'hFFFF_FFFF));
      dir_rows.push_back(csr_row(CSR_UNUSED_HI, 32'h0000_0000));
      dir_rows.push_back(tick_row(32'd8, -1, 1));
      dir_rows.push_back(csr_row(CSR_HEAT_ENABLE, 32'hFFFF_FFFE));   // bit 0 clear: off
      dir_rows.push_back(tick_row(32'd100, 0, 0));
      dir_rows.push_back(tick_row(32'd200, -4096, 4095));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            settle();
            write_csr(row.idx, row.data);
         end else begin
            send_tick(row.t, row.outdoor, row.room, row.typed, row.want);
         end
      end

      // random phases over several register settings
      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         calm = (p % 4 == 3);
         case (p)
            0: program_channel(1'b1, 13'sd4095, 32'd1, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
            1: program_channel(1'b1, -13'sd4096, 32'hFFFF_FFFF, 16'sh8000, 16'sh7FFF,
                               16'sh8000);
            2: program_channel(1'b0, 13'($urandom), $urandom_range(1, 500), 16'($urandom),
                               16'($urandom), 16'($urandom));
            default: program_channel(1'b1, 13'($urandom),
                                     ($urandom_range(0, 9) < 6) ? $urandom_range(1, 2000) :
                                     ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom,
                                     16'($urandom), 16'($urandom),
                                     16'(($urandom_range(0, 3) == 0) ? 16'sd0 : $urandom));
         endcase
         if ($urandom_range(0, 3) == 0)
            write_csr(3'(CSR_UNUSED_LO + $urandom_range(0, 1)), $urandom);
         random_ticks((p == 2) ? 40 : PHASE_TICKS, (p == 5) ? 60 : -1);
      end

      // push large errors into the accumulator, with the duty pinned at both ends
      settle();
      calm = 1'b1;
      program_channel(1'b1, 13'sd4095, 32'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      for (int k = 0; k < SAT_RUN_TICKS; k++)
         send_tick($urandom, rand_temp(), -13'sd4096, 1'b0, '0);
      settle();
      write_csr(CSR_INT_GAIN, 32'h0000_8000);
      write_csr(CSR_DUTY_M10, 32'h0000_8000);
      write_csr(CSR_DUTY_P10, 32'h0000_8000);
      for (int k = 0; k < SAT_RUN_TICKS; k++)
         send_tick($urandom, rand_temp(), -13'sd4096, 1'b0, '0);
      // swing the error the other way
      settle();
      write_csr(CSR_SETPOINT, 32'h0000_1000);
      for (int k = 0; k < 20; k++)
         send_tick($urandom, rand_temp(), 13'sd4095, 1'b0, '0);
      calm = 1'b0;

      @(negedge clock);
      req_valid = 1'b0;
      while (heat_cycles_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/rhcc_pkg.sv
hdl/radiator_heating_curve_controller.sv
test/tb.sv
